>>> rtl/xtt_pkg.sv
`timescale 1ns / 1ps

package xtt_pkg;

   localparam int CharWidth  = 8;
   localparam int PhaseWidth = 4;

   // tokenizer phases
   localparam logic [PhaseWidth-1:0] PH_SEEK    = 4'd0;
   localparam logic [PhaseWidth-1:0] PH_OPEN    = 4'd1;
   localparam logic [PhaseWidth-1:0] PH_TSTART  = 4'd2;
   localparam logic [PhaseWidth-1:0] PH_TITLE   = 4'd3;
   localparam logic [PhaseWidth-1:0] PH_GAP     = 4'd4;
   localparam logic [PhaseWidth-1:0] PH_NAME    = 4'd5;
   localparam logic [PhaseWidth-1:0] PH_EQ      = 4'd6;
   localparam logic [PhaseWidth-1:0] PH_VALUE   = 4'd7;
   localparam logic [PhaseWidth-1:0] PH_CLOSE   = 4'd8;
   localparam logic [PhaseWidth-1:0] PH_DISCARD = 4'd9;

   // token kinds
   localparam logic [2:0] KIND_SKIP  = 3'd0;
   localparam logic [2:0] KIND_OPEN  = 3'd1;
   localparam logic [2:0] KIND_SLASH = 3'd2;
   localparam logic [2:0] KIND_TITLE = 3'd3;
   localparam logic [2:0] KIND_NAME  = 3'd4;
   localparam logic [2:0] KIND_VALUE = 3'd5;
   localparam logic [2:0] KIND_SEP   = 3'd6;
   localparam logic [2:0] KIND_CLOSE = 3'd7;

   // tag types
   localparam logic [1:0] TAG_BEGIN  = 2'd0;
   localparam logic [1:0] TAG_END    = 2'd1;
   localparam logic [1:0] TAG_SINGLE = 2'd2;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_NO_TITLE = 3'd1;
   localparam logic [2:0] ERR_NO_EQ    = 3'd2;
   localparam logic [2:0] ERR_NO_QUOTE = 3'd3;
   localparam logic [2:0] ERR_DBL_SL   = 3'd4;
   localparam logic [2:0] ERR_NO_CLOSE = 3'd5;

   // characters
   localparam logic [CharWidth-1:0] CH_LT    = 8'h3C;
   localparam logic [CharWidth-1:0] CH_GT    = 8'h3E;
   localparam logic [CharWidth-1:0] CH_EQ    = 8'h3D;
   localparam logic [CharWidth-1:0] CH_SLASH = 8'h2F;
   localparam logic [CharWidth-1:0] CH_USCR  = 8'h5F;
   localparam logic [CharWidth-1:0] CH_SPACE = 8'h20;
   localparam logic [CharWidth-1:0] CH_NL    = 8'h0A;
   localparam logic [CharWidth-1:0] CH_QUOTE = 8'h22;
   localparam logic [CharWidth-1:0] CH_BSL   = 8'h5C;

   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic [1:0]            tag_kind;
      logic                  in_quote;
      logic                  after_bsl;
   } state_type;

   typedef struct packed {
      logic [CharWidth-1:0] char_out;
      logic [2:0]           kind;
      logic                 attr_done;
      logic                 attr_has_value;
      logic                 tag_done;
      logic [1:0]           tag_type;
      logic [2:0]           error;
   } result_type;

endpackage

>>> rtl/xtt_step.sv
`timescale 1ns / 1ps

module xtt_step
   import xtt_pkg::*;
(
   input  logic [CharWidth-1:0] ch,
   input  state_type            st,
   output state_type            st_next,
   output result_type           res
);

   logic       is_word;
   logic       is_blank;
   logic       gap_req;
   logic       slash_req;
   logic       close_req;
   logic       fail_req;
   logic [2:0] fail_code;

   assign is_word = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) ||
                    (ch >= 8'h30 && ch <= 8'h39) || ch == CH_USCR;
   assign is_blank = ch == CH_SPACE || ch == CH_NL;

   always_comb begin
      st_next      = st;
      res          = '0;
      res.char_out = ch;
      gap_req      = 1'b0;
      slash_req    = 1'b0;
      close_req    = 1'b0;
      fail_req     = 1'b0;
      fail_code    = ERR_NONE;

      unique case (st.phase)
         PH_OPEN, PH_TSTART: begin
            if (st.phase == PH_OPEN && ch == CH_SLASH) begin
               res.kind         = KIND_SLASH;
               st_next.tag_kind = TAG_END;
               st_next.phase    = PH_TSTART;
            end else if (is_word) begin
               res.kind      = KIND_TITLE;
               st_next.phase = PH_TITLE;
            end else begin
               fail_req  = 1'b1;
               fail_code = ERR_NO_TITLE;
            end
         end
         PH_TITLE: begin
            if (is_word) res.kind = KIND_TITLE;
            else gap_req = 1'b1;
         end
         PH_GAP: gap_req = 1'b1;
         PH_NAME: begin
            if (is_word) begin
               res.kind = KIND_NAME;
            end else if (is_blank || ch == CH_SLASH || ch == CH_GT) begin
               res.attr_done = 1'b1;
               gap_req       = 1'b1;
            end else if (ch == CH_EQ) begin
               res.kind      = KIND_SEP;
               st_next.phase = PH_EQ;
            end else begin
               fail_req  = 1'b1;
               fail_code = ERR_NO_EQ;
            end
         end
         PH_EQ: begin
            if (ch == CH_QUOTE) begin
               res.kind          = KIND_SEP;
               st_next.in_quote  = 1'b1;
               st_next.after_bsl = 1'b0;
               st_next.phase     = PH_VALUE;
            end else begin
               fail_req  = 1'b1;
               fail_code = ERR_NO_QUOTE;
            end
         end
         PH_VALUE: begin
            if (st.after_bsl) begin
               res.kind          = KIND_VALUE;
               st_next.after_bsl = 1'b0;
            end else if (ch == CH_BSL) begin
               res.kind          = KIND_SKIP;
               st_next.after_bsl = 1'b1;
            end else if (ch == CH_QUOTE) begin
               res.kind           = KIND_SEP;
               res.attr_done      = 1'b1;
               res.attr_has_value = 1'b1;
               st_next.in_quote   = 1'b0;
               st_next.phase      = PH_GAP;
            end else begin
               res.kind = KIND_VALUE;
            end
         end
         PH_CLOSE: begin
            if (ch == CH_GT) begin
               close_req = 1'b1;
            end else begin
               fail_req  = 1'b1;
               fail_code = ERR_NO_CLOSE;
            end
         end
         PH_DISCARD: begin
            if (st.in_quote) begin
               if (st.after_bsl) st_next.after_bsl = 1'b0;
               else if (ch == CH_BSL) st_next.after_bsl = 1'b1;
               else if (ch == CH_QUOTE) st_next.in_quote = 1'b0;
            end else if (ch == CH_QUOTE) begin
               st_next.in_quote  = 1'b1;
               st_next.after_bsl = 1'b0;
            end else if (ch == CH_GT) begin
               st_next.phase = PH_SEEK;
            end
         end
         default: begin
            // seeking, and any code without a meaning
            st_next.phase     = PH_SEEK;
            st_next.in_quote  = 1'b0;
            st_next.after_bsl = 1'b0;
            st_next.tag_kind  = TAG_BEGIN;
            if (ch == CH_LT) begin
               res.kind      = KIND_OPEN;
               st_next.phase = PH_OPEN;
            end
         end
      endcase

      // character after title, name, separator or value
      if (gap_req) begin
         if (is_blank) begin
            res.kind      = KIND_SEP;
            st_next.phase = PH_GAP;
         end else if (is_word) begin
            res.kind      = KIND_NAME;
            st_next.phase = PH_NAME;
         end else if (ch == CH_SLASH) begin
            slash_req = 1'b1;
         end else if (ch == CH_GT) begin
            close_req = 1'b1;
         end else begin
            fail_req  = 1'b1;
            fail_code = ERR_NO_CLOSE;
         end
      end

      if (slash_req) begin
         if (st.tag_kind == TAG_END) begin
            fail_req  = 1'b1;
            fail_code = ERR_DBL_SL;
         end else begin
            st_next.tag_kind = TAG_SINGLE;
            res.kind         = KIND_SLASH;
            st_next.phase    = PH_CLOSE;
         end
      end

      if (close_req) begin
         res.kind         = KIND_CLOSE;
         res.tag_done     = 1'b1;
         res.tag_type     = st.tag_kind;
         st_next.tag_kind = TAG_BEGIN;
         st_next.phase    = PH_SEEK;
      end

      // error: report once, then drop up to the unquoted close
      if (fail_req) begin
         res.kind          = KIND_SKIP;
         res.error         = fail_code;
         st_next.after_bsl = 1'b0;
         st_next.tag_kind  = TAG_BEGIN;
         st_next.in_quote  = ch == CH_QUOTE;
         st_next.phase     = (ch == CH_GT) ? PH_SEEK : PH_DISCARD;
      end
   end

endmodule

>>> rtl/xml_tag_tokenizer.sv
`timescale 1ns / 1ps

// Streaming XML tag tokenizer: one character in, one classified character out.
// Each character is taken into an input register; from there its token kind,
// attribute and tag flags and any error code are decided from the tokenizer
// state and written to the result register, which holds it until the transfer
// on the rsp_ side. Throughput is one character per cycle while the rsp_ side
// is ready; a character's result passes through the input register and then
// the result register before it is presented on the rsp_ side. The state
// register (phase, tag type, quote and escape flags) is updated together with
// the result register, which sets that rate. After reset the block takes
// characters at once.
module xml_tag_tokenizer
   import xtt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [CharWidth-1:0] req_char_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CharWidth-1:0] rsp_char_out,
   output logic [2:0]           rsp_kind,
   output logic                 rsp_attr_done,
   output logic                 rsp_attr_has_value,
   output logic                 rsp_tag_done,
   output logic [1:0]           rsp_tag_type,
   output logic [2:0]           rsp_error
);

   logic                 in_valid_ff;
   logic [CharWidth-1:0] in_char_ff;
   logic                 out_valid_ff;
   result_type           out_ff;
   state_type            state_ff;
   state_type            state_in;
   result_type           result_in;
   logic                 advance;

   xtt_step u_step (
      .ch      (in_char_ff),
      .st      (state_ff),
      .st_next (state_in),
      .res     (result_in)
   );

   // held character moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_SEEK, tag_kind: TAG_BEGIN, in_quote: 1'b0,
                           after_bsl: 1'b0};
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) in_char_ff <= req_char_in;
      if (advance) out_ff <= result_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_char_out       = out_ff.char_out;
   assign rsp_kind           = out_ff.kind;
   assign rsp_attr_done      = out_ff.attr_done;
   assign rsp_attr_has_value = out_ff.attr_has_value;
   assign rsp_tag_done       = out_ff.tag_done;
   assign rsp_tag_type       = out_ff.tag_type;
   assign rsp_error          = out_ff.error;

`ifndef SYNTHESIS
   a_close_is_tag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_CLOSE) |-> rsp_tag_done)
      else $error("close token without tag completion");

   a_tag_is_close: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_tag_done |-> (rsp_kind == KIND_CLOSE) && (rsp_error == ERR_NONE))
      else $error("tag completion on a non-close token");

   a_error_skips: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error != ERR_NONE) |-> (rsp_kind == KIND_SKIP))
      else $error("error reported on a kept token");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("result lost after advance");

   a_discard_via_error: assert property (@(posedge clock) disable iff (reset)
      advance && (state_in.phase == PH_DISCARD) && (state_ff.phase != PH_DISCARD)
      |=> rsp_error != ERR_NONE)
      else $error("discarding started without an error");
`endif

endmodule
